// ----- rtl/ptc_pkg.sv -----
// Shared types, codes and constants for the per-MAC traffic counter table.
package ptc_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int TABLE_MAX         = 256;
  localparam int IDX_W             = $clog2(TABLE_MAX);
  localparam int CNT_W             = $clog2(TABLE_MAX + 1);

  localparam int MAC_W   = 48;
  localparam int CTR_W   = 64;
  localparam int TIME_W  = 32;
  localparam int LEN_W   = 16;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 3;
  localparam int MCAST_BIT = 40;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd300000;

  localparam logic [OP_W-1:0] OP_PACKET    = 3'd0;
  localparam logic [OP_W-1:0] OP_TICK      = 3'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 3'd2;
  localparam logic [OP_W-1:0] OP_RESET_ONE = 3'd3;
  localparam logic [OP_W-1:0] OP_RESET_ALL = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 3'd0;
  localparam logic [STAT_W-1:0] ST_MCAST     = 3'd1;
  localparam logic [STAT_W-1:0] ST_OWN_AP    = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic REG_AP_MAC  = 1'b0;
  localparam logic REG_TIMEOUT = 1'b1;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_UPDATE,
    CMD_INSERT,
    CMD_EVICT_INSERT,
    CMD_TICK,
    CMD_CLEAR_ONE,
    CMD_CLEAR_ALL
  } cmd_kind_t;

  typedef struct packed {
    logic              valid;
    logic              active;
    logic [MAC_W-1:0]  mac;
    logic [CTR_W-1:0]  upl;
    logic [CTR_W-1:0]  dnl;
    logic [TIME_W-1:0] ls;
  } entry_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [MAC_W-1:0]  mac;
    logic [LEN_W-1:0]  len;
    logic              upl;
    logic [TIME_W-1:0] tstamp;
    logic [TIME_W-1:0] timeout;
  } cmd_t;

  typedef struct packed {
    logic [MAC_W-1:0] key;
    logic             sel_en;
    logic [IDX_W-1:0] sel_idx;
  } look_t;

  typedef struct packed {
    logic              hit;
    logic [IDX_W-1:0]  hit_idx;
    logic              found;
    logic [TIME_W-1:0] best_ls;
    logic [IDX_W-1:0]  best_idx;
    logic [CNT_W-1:0]  cnt;
    logic [CTR_W-1:0]  sel_upl;
    logic [CTR_W-1:0]  sel_dnl;
    logic [TIME_W-1:0] sel_ls;
    logic              sel_act;
  } scan_t;

endpackage

// ----- rtl/ptc_cell.sv -----
// One table entry with its update logic and its stage of the lookup chain.
module ptc_cell
  import ptc_pkg::*;
#(
  parameter int IDX     = 0,
  parameter bit IS_LAST = 1'b0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  cmd_t   cmd,
  input  look_t  look,
  input  scan_t  scan_in,
  input  entry_t next_entry,
  output entry_t entry,
  output scan_t  scan_out
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic              valid_r, valid_nxt;
  logic              active_r, active_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [CTR_W-1:0]  upl_r, upl_nxt;
  logic [CTR_W-1:0]  dnl_r, dnl_nxt;
  logic [TIME_W-1:0] ls_r, ls_nxt;
  scan_t             scan_r, scan_nxt;
  logic [CTR_W-1:0]  len_ext;
  logic [TIME_W-1:0] age;

  assign entry    = '{valid: valid_r, active: active_r, mac: mac_r,
                      upl: upl_r, dnl: dnl_r, ls: ls_r};
  assign scan_out = scan_r;
  assign len_ext  = {{(CTR_W - LEN_W){1'b0}}, cmd.len};
  assign age      = cmd.tstamp - ls_r;

  always_comb begin
    valid_nxt  = valid_r;
    active_nxt = active_r;
    mac_nxt    = mac_r;
    upl_nxt    = upl_r;
    dnl_nxt    = dnl_r;
    ls_nxt     = ls_r;
    case (cmd.kind)
      CMD_UPDATE: begin
        if (cmd.idx == MY_IDX) begin
          if (cmd.upl) begin
            upl_nxt = upl_r + len_ext;
          end else begin
            dnl_nxt = dnl_r + len_ext;
          end
          ls_nxt     = cmd.tstamp;
          active_nxt = 1'b1;
        end
      end
      CMD_INSERT, CMD_EVICT_INSERT: begin
        if ((cmd.kind == CMD_INSERT && cmd.idx == MY_IDX) ||
            (cmd.kind == CMD_EVICT_INSERT && IS_LAST)) begin
          valid_nxt  = 1'b1;
          active_nxt = 1'b1;
          mac_nxt    = cmd.mac;
          upl_nxt    = cmd.upl ? len_ext : '0;
          dnl_nxt    = cmd.upl ? '0 : len_ext;
          ls_nxt     = cmd.tstamp;
        end else if (cmd.kind == CMD_EVICT_INSERT && MY_IDX >= cmd.idx) begin
          valid_nxt  = next_entry.valid;
          active_nxt = next_entry.active;
          mac_nxt    = next_entry.mac;
          upl_nxt    = next_entry.upl;
          dnl_nxt    = next_entry.dnl;
          ls_nxt     = next_entry.ls;
        end
      end
      CMD_TICK: begin
        if (valid_r && active_r && age > cmd.timeout) begin
          active_nxt = 1'b0;
        end
      end
      CMD_CLEAR_ONE: begin
        if (cmd.idx == MY_IDX) begin
          upl_nxt = '0;
          dnl_nxt = '0;
        end
      end
      CMD_CLEAR_ALL: begin
        upl_nxt = '0;
        dnl_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    scan_nxt = scan_in;
    if (!scan_in.hit && valid_r && mac_r == look.key) begin
      scan_nxt.hit     = 1'b1;
      scan_nxt.hit_idx = MY_IDX;
    end
    if (valid_r && !active_r && (!scan_in.found || ls_r < scan_in.best_ls)) begin
      scan_nxt.found    = 1'b1;
      scan_nxt.best_ls  = ls_r;
      scan_nxt.best_idx = MY_IDX;
    end
    if (active_r) begin
      scan_nxt.cnt = scan_in.cnt + CNT_W'(1);
    end
    if (look.sel_en && look.sel_idx == MY_IDX) begin
      scan_nxt.sel_upl = upl_r;
      scan_nxt.sel_dnl = dnl_r;
      scan_nxt.sel_ls  = ls_r;
      scan_nxt.sel_act = active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      active_r <= 1'b0;
    end else begin
      valid_r  <= valid_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mac_r  <= mac_nxt;
    upl_r  <= upl_nxt;
    dnl_r  <= dnl_nxt;
    ls_r   <= ls_nxt;
    scan_r <= scan_nxt;
  end

endmodule

// ----- rtl/per_mac_traffic_counter_table.sv -----
// Top level: sequencer, configuration registers and the chain of table cells.
// Busy is high from the accepting edge until the result is registered, so the block takes no new
// item before it is through with the last one.
// Each item makes two passes through the cell chain, one for lookup and one for the count.
// The result strobe lasts one cycle and cannot be stalled by the receiver.
// Synchronous active-low reset empties the table, clears the time and restores the registers.
module per_mac_traffic_counter_table
  import ptc_pkg::*;
#(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int AC_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   in_operation,
  input  logic [MAC_W-1:0]  in_src_mac,
  input  logic [MAC_W-1:0]  in_dst_mac,
  input  logic [LEN_W-1:0]  in_packet_length,
  input  logic              in_is_upload,
  input  logic [MAC_W-1:0]  in_key_mac,
  output logic              out_valid,
  output logic [STAT_W-1:0] out_status,
  output logic [CTR_W-1:0]  out_upload_bytes,
  output logic [CTR_W-1:0]  out_download_bytes,
  output logic [TIME_W-1:0] out_seen_time,
  output logic              out_entry_is_active,
  output logic [AC_W-1:0]   out_active_count
);

  localparam int CYC_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CYC_W-1:0] CYC_LAST = CYC_W'(TABLE_ENTRIES);
  localparam logic [CYC_W-1:0] USED_MAX = CYC_W'(TABLE_ENTRIES);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_APPLY, S_COUNT} state_t;

  state_t            state_r;
  logic [CYC_W-1:0]  cyc_r;
  logic [OP_W-1:0]   op_r;
  logic              mcast_r;
  logic [MAC_W-1:0]  key_r;
  logic [LEN_W-1:0]  len_r;
  logic              upl_r;
  logic              sel_en_r;
  logic [IDX_W-1:0]  sel_idx_r;
  cmd_t              cmd_r, cmd_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              sel_en_nxt;
  logic [IDX_W-1:0]  sel_idx_nxt;
  logic [CYC_W-1:0]  used_r, used_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [MAC_W-1:0]  ap_mac_r;
  logic [TIME_W-1:0] timeout_r;
  logic              out_valid_r;
  logic [STAT_W-1:0] out_status_r;
  logic [CTR_W-1:0]  out_upl_r, out_dnl_r;
  logic [TIME_W-1:0] out_ls_r;
  logic              out_act_r;
  logic [AC_W-1:0]   out_cnt_r;

  look_t  look;
  scan_t  scan_q [TABLE_ENTRIES];
  entry_t ent_q  [TABLE_ENTRIES];
  scan_t  fin;
  logic   in_xfer;
  logic   cfg_wr;

  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;
  assign busy      = (state_r != S_IDLE);
  assign in_xfer   = start && !busy;
  assign look      = '{key: key_r, sel_en: sel_en_r, sel_idx: sel_idx_r};
  assign fin       = scan_q[TABLE_ENTRIES-1];

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_upload_bytes    = out_upl_r;
  assign out_download_bytes  = out_dnl_r;
  assign out_seen_time       = out_ls_r;
  assign out_entry_is_active = out_act_r;
  assign out_active_count    = out_cnt_r;

  always_comb begin
    case (paddr[3])
      REG_AP_MAC:  prdata = {{(64 - MAC_W){1'b0}}, ap_mac_r};
      REG_TIMEOUT: prdata = {{(64 - TIME_W){1'b0}}, timeout_r};
      default:     prdata = '0;
    endcase
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    scan_t  prev;
    entry_t nbr;
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = scan_q[i-1];
    end
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = ent_q[i+1];
    end
    ptc_cell #(
      .IDX     (i),
      .IS_LAST (i == TABLE_ENTRIES - 1)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd_r),
      .look       (look),
      .scan_in    (prev),
      .next_entry (nbr),
      .entry      (ent_q[i]),
      .scan_out   (scan_q[i])
    );
  end

  always_comb begin
    cmd_nxt         = '0;
    cmd_nxt.kind    = CMD_NONE;
    cmd_nxt.mac     = key_r;
    cmd_nxt.len     = len_r;
    cmd_nxt.upl     = upl_r;
    cmd_nxt.tstamp  = time_r;
    cmd_nxt.timeout = timeout_r;
    status_nxt      = ST_DONE;
    sel_en_nxt      = 1'b0;
    sel_idx_nxt     = '0;
    used_nxt        = used_r;
    time_nxt        = time_r;
    case (op_r)
      OP_PACKET: begin
        if (mcast_r) begin
          status_nxt = ST_MCAST;
        end else if (key_r == ap_mac_r) begin
          status_nxt = ST_OWN_AP;
        end else if (fin.hit) begin
          cmd_nxt.kind = CMD_UPDATE;
          cmd_nxt.idx  = fin.hit_idx;
          sel_en_nxt   = 1'b1;
          sel_idx_nxt  = fin.hit_idx;
        end else if (used_r < USED_MAX) begin
          cmd_nxt.kind = CMD_INSERT;
          cmd_nxt.idx  = IDX_W'(used_r);
          sel_en_nxt   = 1'b1;
          sel_idx_nxt  = IDX_W'(used_r);
          used_nxt     = used_r + CYC_W'(1);
        end else if (fin.found) begin
          cmd_nxt.kind = CMD_EVICT_INSERT;
          cmd_nxt.idx  = fin.best_idx;
          sel_en_nxt   = 1'b1;
          sel_idx_nxt  = IDX_W'(TABLE_ENTRIES - 1);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      OP_TICK: begin
        time_nxt       = time_r + TIME_W'(1);
        cmd_nxt.kind   = CMD_TICK;
        cmd_nxt.tstamp = time_nxt;
      end
      OP_QUERY, OP_RESET_ONE: begin
        if (fin.hit) begin
          if (op_r == OP_RESET_ONE) begin
            cmd_nxt.kind = CMD_CLEAR_ONE;
            cmd_nxt.idx  = fin.hit_idx;
          end
          sel_en_nxt  = 1'b1;
          sel_idx_nxt = fin.hit_idx;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      OP_RESET_ALL: begin
        cmd_nxt.kind = CMD_CLEAR_ALL;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ap_mac_r  <= '0;
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr) begin
      case (paddr[3])
        REG_AP_MAC:  ap_mac_r  <= pwdata[MAC_W-1:0];
        REG_TIMEOUT: timeout_r <= pwdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cyc_r       <= '0;
      cmd_r       <= '0;
      sel_en_r    <= 1'b0;
      used_r      <= '0;
      time_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_COUNT) && (cyc_r == CYC_LAST);
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r   <= S_SCAN;
            cyc_r     <= '0;
            sel_en_r  <= 1'b0;
            op_r      <= in_operation;
            mcast_r   <= in_src_mac[MCAST_BIT] || in_dst_mac[MCAST_BIT];
            len_r     <= in_packet_length;
            upl_r     <= in_is_upload;
            if (in_operation == OP_PACKET) begin
              key_r <= in_is_upload ? in_src_mac : in_dst_mac;
            end else begin
              key_r <= in_key_mac;
            end
          end
        end
        S_SCAN: begin
          cyc_r <= cyc_r + CYC_W'(1);
          if (cyc_r == CYC_LAST) begin
            state_r   <= S_APPLY;
            cmd_r     <= cmd_nxt;
            status_r  <= status_nxt;
            sel_en_r  <= sel_en_nxt;
            sel_idx_r <= sel_idx_nxt;
            used_r    <= used_nxt;
            time_r    <= time_nxt;
          end
        end
        S_APPLY: begin
          state_r    <= S_COUNT;
          cyc_r      <= '0;
          cmd_r.kind <= CMD_NONE;
        end
        S_COUNT: begin
          cyc_r <= cyc_r + CYC_W'(1);
          if (cyc_r == CYC_LAST) begin
            state_r      <= S_IDLE;
            out_status_r <= status_r;
            out_upl_r    <= fin.sel_upl;
            out_dnl_r    <= fin.sel_dnl;
            out_ls_r     <= fin.sel_ls;
            out_act_r    <= fin.sel_act;
            out_cnt_r    <= fin.cnt[AC_W-1:0];
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> busy)
    else $error("accepted item did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_strobe_after_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_COUNT))
    else $error("result strobe without a finished count pass");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= USED_MAX)
    else $error("used slot count beyond table size");

  a_active_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> CYC_W'(out_active_count) <= used_r)
    else $error("active count exceeds used slots");
`endif

endmodule

// ----- dv/tb_per_mac_traffic_counter_table.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the per-MAC traffic counter table with its own table predictor.
module tb_per_mac_traffic_counter_table;
  import ptc_pkg::*;

  localparam int NSLOT = TABLE_ENTRIES_DEF;
  localparam int AC_W = $clog2(NSLOT + 1);
  localparam logic [3:0] ADDR_AP_MAC = 4'd0;
  localparam logic [3:0] ADDR_TIMEOUT = 4'd8;
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
  localparam int POOL_N = 22;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 230;
  localparam int SETTLE = 40;
  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [MAC_W-1:0] src;
    logic [MAC_W-1:0] dst;
    logic [LEN_W-1:0] len;
    logic             up;
    logic [MAC_W-1:0] key;
  } pkt_item_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CTR_W-1:0]  upl;
    logic [CTR_W-1:0]  dnl;
    logic [TIME_W-1:0] seen;
    logic              act;
    logic [AC_W-1:0]   nact;
  } acct_reply_t;

  class counter_table_scoreboard;
    logic [MAC_W-1:0]  ap_mac_r;
    logic [TIME_W-1:0] timeout_r;
    logic [MAC_W-1:0]  mac_s[NSLOT];
    logic [CTR_W-1:0]  upl_s[NSLOT];
    logic [CTR_W-1:0]  dnl_s[NSLOT];
    logic [TIME_W-1:0] seen_s[NSLOT];
    bit                act_s[NSLOT];
    int                used_n;
    logic [TIME_W-1:0] now_t;
    acct_reply_t       expected_replies[$];
    int                mismatches;
    int                items_noted;
    int                evictions;
    int                status_hits[8];

    function new();
      ap_mac_r = '0;
      timeout_r = TIMEOUT_RESET;
      foreach (act_s[i]) act_s[i] = 1'b0;
      foreach (status_hits[i]) status_hits[i] = 0;
      used_n = 0;
      now_t = '0;
      mismatches = 0;
      items_noted = 0;
      evictions = 0;
    endfunction

    function void write_reg(logic reg_sel, logic [63:0] val);
      if (reg_sel == REG_AP_MAC) begin
        ap_mac_r = val[MAC_W-1:0];
      end else begin
        timeout_r = val[TIME_W-1:0];
      end
    endfunction

    function int find_slot(logic [MAC_W-1:0] m);
      for (int i = 0; i < used_n; i++) begin
        if (mac_s[i] == m) return i;
      end
      return -1;
    endfunction

    function int active_total();
      int n;
      n = 0;
      for (int i = 0; i < used_n; i++) begin
        if (act_s[i]) n++;
      end
      return n;
    endfunction

    function void remove_at(int k);
      for (int i = k; i + 1 < used_n; i++) begin
        mac_s[i] = mac_s[i+1];
        upl_s[i] = upl_s[i+1];
        dnl_s[i] = dnl_s[i+1];
        seen_s[i] = seen_s[i+1];
        act_s[i] = act_s[i+1];
      end
      act_s[used_n-1] = 1'b0;
      used_n--;
    endfunction

    // Returns the client's slot, appending it (after an eviction if needed), or -1 when full.
    function int place_client(logic [MAC_W-1:0] m);
      int k;
      int best;
      bit found;
      k = find_slot(m);
      if (k >= 0) return k;
      if (used_n >= NSLOT) begin
        best = 0;
        found = 1'b0;
        for (int i = 0; i < NSLOT; i++) begin
          if (!act_s[i] && (!found || seen_s[i] < seen_s[best])) begin
            best = i;
            found = 1'b1;
          end
        end
        if (!found) return -1;
        remove_at(best);
        evictions++;
      end
      k = used_n;
      mac_s[k] = m;
      upl_s[k] = '0;
      dnl_s[k] = '0;
      seen_s[k] = now_t;
      act_s[k] = 1'b1;
      used_n++;
      return k;
    endfunction

    function acct_reply_t slot_view(int k);
      acct_reply_t r;
      r = '0;
      r.status = ST_DONE;
      r.upl = upl_s[k];
      r.dnl = dnl_s[k];
      r.seen = seen_s[k];
      r.act = act_s[k];
      return r;
    endfunction

    function void note_item(pkt_item_t it);
      acct_reply_t r;
      logic [MAC_W-1:0] client;
      int k;
      r = '0;
      case (it.op)
        OP_PACKET: begin
          client = it.up ? it.src : it.dst;
          if (it.src[MCAST_BIT] || it.dst[MCAST_BIT]) begin
            r.status = ST_MCAST;
          end else if (client == ap_mac_r) begin
            r.status = ST_OWN_AP;
          end else begin
            k = place_client(client);
            if (k < 0) begin
              r.status = ST_FULL;
            end else begin
              if (it.up) upl_s[k] += CTR_W'(it.len);
              else dnl_s[k] += CTR_W'(it.len);
              seen_s[k] = now_t;
              act_s[k] = 1'b1;
              r = slot_view(k);
            end
          end
        end
        OP_TICK: begin
          now_t = now_t + 1'b1;
          for (int i = 0; i < used_n; i++) begin
            if (act_s[i] && (now_t - seen_s[i]) > timeout_r) act_s[i] = 1'b0;
          end
        end
        OP_QUERY, OP_RESET_ONE: begin
          k = find_slot(it.key);
          if (k < 0) begin
            r.status = ST_NOT_FOUND;
          end else begin
            if (it.op == OP_RESET_ONE) begin
              upl_s[k] = '0;
              dnl_s[k] = '0;
            end
            r = slot_view(k);
          end
        end
        OP_RESET_ALL: begin
          for (int i = 0; i < used_n; i++) begin
            upl_s[i] = '0;
            dnl_s[i] = '0;
          end
        end
        default: begin
        end
      endcase
      r.nact = AC_W'(active_total());
      status_hits[r.status]++;
      items_noted++;
      expected_replies = {expected_replies, r};
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    task check_reply(acct_reply_t got);
      acct_reply_t want;
      if (expected_replies.size() == 0) begin
        report("reply with nothing outstanding, status", 64'(got.status), '0);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status)
        report("status", 64'(got.status), 64'(want.status));
      if (got.upl !== want.upl) report("upload_bytes", got.upl, want.upl);
      if (got.dnl !== want.dnl) report("download_bytes", got.dnl, want.dnl);
      if (got.seen !== want.seen) report("seen_time", 64'(got.seen), 64'(want.seen));
      if (got.act !== want.act) report("entry_is_active", 64'(got.act), 64'(want.act));
      if (got.nact !== want.nact) report("active_count", 64'(got.nact), 64'(want.nact));
    endtask
  endclass

  logic              clk;
  logic              rst_n = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [63:0]       pwdata = '0;
  logic [63:0]       prdata;
  logic              pready;
  logic              start = 1'b0;
  logic              busy;
  logic [OP_W-1:0]   in_operation = '0;
  logic [MAC_W-1:0]  in_src_mac = '0;
  logic [MAC_W-1:0]  in_dst_mac = '0;
  logic [LEN_W-1:0]  in_packet_length = '0;
  logic              in_is_upload = 1'b0;
  logic [MAC_W-1:0]  in_key_mac = '0;
  logic              out_valid;
  logic [STAT_W-1:0] out_status;
  logic [CTR_W-1:0]  out_upload_bytes;
  logic [CTR_W-1:0]  out_download_bytes;
  logic [TIME_W-1:0] out_seen_time;
  logic              out_entry_is_active;
  logic [AC_W-1:0]   out_active_count;

  counter_table_scoreboard sb = new();
  logic [MAC_W-1:0] client_pool[POOL_N];
  int quiet_cycles = 0;

  per_mac_traffic_counter_table i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_src_mac          (in_src_mac),
    .in_dst_mac          (in_dst_mac),
    .in_packet_length    (in_packet_length),
    .in_is_upload        (in_is_upload),
    .in_key_mac          (in_key_mac),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_upload_bytes    (out_upload_bytes),
    .out_download_bytes  (out_download_bytes),
    .out_seen_time       (out_seen_time),
    .out_entry_is_active (out_entry_is_active),
    .out_active_count    (out_active_count)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    acct_reply_t got;
    pkt_item_t   it;
    if (rst_n) begin
      if (psel && penable && pwrite && pready) sb.write_reg(paddr[3], pwdata);
      if (out_valid) begin
        got.status = out_status;
        got.upl = out_upload_bytes;
        got.dnl = out_download_bytes;
        got.seen = out_seen_time;
        got.act = out_entry_is_active;
        got.nact = out_active_count;
        sb.check_reply(got);
      end
      if (start && !busy) begin
        it.op = in_operation;
        it.src = in_src_mac;
        it.dst = in_dst_mac;
        it.len = in_packet_length;
        it.up = in_is_upload;
        it.key = in_key_mac;
        sb.note_item(it);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_per_mac_traffic_counter_table: errors");
        $finish;
      end
    end
  end

  function automatic logic [MAC_W-1:0] rand_mac();
    logic [MAC_W-1:0] m;
    m[47:32] = 16'($urandom_range(16'hFFFF));
    m[31:0] = $urandom;
    return m;
  endfunction

  function automatic pkt_item_t mk_item(logic [OP_W-1:0] op, logic [MAC_W-1:0] src,
                                        logic [MAC_W-1:0] dst, logic [LEN_W-1:0] len,
                                        logic up, logic [MAC_W-1:0] key);
    pkt_item_t it;
    it.op = op;
    it.src = src;
    it.dst = dst;
    it.len = len;
    it.up = up;
    it.key = key;
    return it;
  endfunction

  // Mostly well-formed packets over a small client pool, with some noise mixed in.
  function automatic pkt_item_t random_item();
    pkt_item_t it;
    logic [MAC_W-1:0] client;
    logic [MAC_W-1:0] peer;
    int r;
    it = mk_item(OP_PACKET, rand_mac(), rand_mac(), 16'($urandom), 1'($urandom), rand_mac());
    r = $urandom_range(99);
    if (r < 58) begin
      client = client_pool[$urandom_range(POOL_N - 1)];
      if ($urandom_range(99) < 5) client = sb.ap_mac_r;
      peer = ($urandom_range(1) == 0) ? client_pool[$urandom_range(POOL_N - 1)] : rand_mac();
      peer[MCAST_BIT] = 1'b0;
      if (it.up) begin
        it.src = client;
        it.dst = peer;
      end else begin
        it.src = peer;
        it.dst = client;
      end
      if ($urandom_range(9) == 0) it.len = ($urandom_range(1) == 0) ? '0 : '1;
    end else if (r < 73) begin
      it.op = OP_TICK;
    end else if (r < 89) begin
      it.op = (r < 83) ? OP_QUERY : OP_RESET_ONE;
      if ($urandom_range(99) < 85) it.key = client_pool[$urandom_range(POOL_N - 1)];
    end else if (r < 92) begin
      it.op = OP_RESET_ALL;
    end else if (r >= 95) begin
      it.op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    return it;
  endfunction

  task automatic send_item(pkt_item_t it, int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 45)) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= it.op;
    in_src_mac <= it.src;
    in_dst_mac <= it.dst;
    in_packet_length <= it.len;
    in_is_upload <= it.up;
    in_key_mac <= it.key;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes a register, then reads it back through the same port.
  task automatic program_reg(logic [3:0] addr, logic [63:0] value);
    logic [63:0] want;
    logic [63:0] rd;
    want = (addr == ADDR_AP_MAC) ? {16'h0, value[MAC_W-1:0]} : {32'h0, value[TIME_W-1:0]};
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (rd !== want) sb.report("register readback", rd, want);
  endtask

  initial begin
    logic [63:0] phase_ap[PHASES];
    logic [63:0] phase_tmo[PHASES];
    int idle_pct;
    logic [MAC_W-1:0] c0;
    logic [MAC_W-1:0] c1;
    logic [MAC_W-1:0] top_ucast;

    foreach (client_pool[i]) begin
      client_pool[i] = rand_mac();
      client_pool[i][MCAST_BIT] = 1'b0;
      client_pool[i][0] = 1'b1;
    end
    c0 = client_pool[0];
    c1 = client_pool[1];
    top_ucast = '1;
    top_ucast[MCAST_BIT] = 1'b0;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(mk_item(OP_QUERY, '0, '0, '0, 1'b0, c0), 0);
    send_item(mk_item(OP_RESET_ONE, '0, '0, '0, 1'b0, c0), 0);
    send_item(mk_item(OP_RESET_ALL, '1, '1, '1, 1'b1, '1), 0);
    send_item(mk_item(OP_PACKET, c0, c1, '1, 1'b1, '0), 0);
    send_item(mk_item(OP_PACKET, c0, c1, '0, 1'b0, '0), 0);
    send_item(mk_item(OP_PACKET, c0, c1, 16'h1234, 1'b1, '0), 0);
    send_item(mk_item(OP_PACKET, '1, c1, 16'h00FF, 1'b0, '0), 0);
    send_item(mk_item(OP_PACKET, '0, 48'h0100_0000_0000, 16'h0010, 1'b1, '0), 0);
    send_item(mk_item(OP_PACKET, '0, c1, 16'h0020, 1'b1, '0), 0);
    send_item(mk_item(OP_PACKET, c0, '0, 16'h0030, 1'b0, '0), 0);
    send_item(mk_item(OP_PACKET, top_ucast, c0, '1, 1'b1, '0), 0);
    send_item(mk_item(OP_TICK, '0, '0, '0, 1'b0, '0), 0);
    send_item(mk_item(OP_QUERY, '0, '0, '0, 1'b0, c0), 0);
    send_item(mk_item(OP_QUERY, '0, '0, '0, 1'b0, c1), 0);
    send_item(mk_item(OP_RESET_ONE, '0, '0, '0, 1'b0, c0), 0);
    send_item(mk_item(OP_QUERY, '0, '0, '0, 1'b0, c0), 0);
    send_item(mk_item(OP_PACKET, c1, top_ucast, 16'h8000, 1'b0, '0), 0);
    send_item(mk_item(OP_RESET_ALL, '0, '0, '0, 1'b0, '0), 0);
    send_item(mk_item(OP_QUERY, '0, '0, '0, 1'b0, top_ucast), 0);
    for (int op = int'(OP_SPARE_LO); op <= int'(OP_SPARE_HI); op++) begin
      send_item(mk_item(OP_W'(op), rand_mac(), rand_mac(), 16'($urandom), 1'($urandom),
                        rand_mac()), 0);
    end
    send_item(mk_item(OP_QUERY, '0, '0, '0, 1'b0, '0), 0);
    drain_replies();

    phase_ap[0] = 64'h0;                      phase_tmo[0] = 64'hFFFF_FFFF;
    phase_ap[1] = {16'h0, client_pool[2]};    phase_tmo[1] = 64'h0;
    phase_ap[2] = 64'hFFFF_FFFF_FFFF_FFFF;    phase_tmo[2] = 64'd3;
    phase_ap[3] = {16'h0, client_pool[5]};    phase_tmo[3] = 64'd1;
    phase_ap[4] = {$urandom, $urandom};       phase_tmo[4] = 64'd20;
    phase_ap[5] = 64'h0;                      phase_tmo[5] = {32'hFFFF_FFFF, 32'd300000};

    for (int p = 0; p < PHASES; p++) begin
      program_reg(ADDR_AP_MAC, phase_ap[p]);
      program_reg(ADDR_TIMEOUT, phase_tmo[p]);
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 57 : 13);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(random_item(), idle_pct);
      end
      drain_replies();
    end

    $display("Covered %0d items over %0d register settings; %0d entries evicted.",
             sb.items_noted, PHASES + 1, sb.evictions);
    $display("Outcomes: done %0d, multicast %0d, own AP %0d, table full %0d, not found %0d.",
             sb.status_hits[ST_DONE], sb.status_hits[ST_MCAST], sb.status_hits[ST_OWN_AP],
             sb.status_hits[ST_FULL], sb.status_hits[ST_NOT_FOUND]);
    if (sb.mismatches == 0) begin
      $display("tb_per_mac_traffic_counter_table: clean");
    end else begin
      $display("tb_per_mac_traffic_counter_table: errors");
    end
    $finish;
  end

endmodule
